// File: rtl/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: fixed-point constants and stage payload types.
// Depends on nothing; used by rtl/hsv_to_rgb_converter.sv.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Field widths
  localparam int unsigned HueW  = 20;
  localparam int unsigned QW    = 14;  // saturation / brightness, signed Q1.12
  localparam int unsigned ChW   = 14;  // output channel width
  localparam int unsigned UnitW = 13;  // 0..4096 after validity check

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // Pipeline depth (registered stages from input to output)
  localparam int unsigned NumStages = 5;

  // Hue wrap: add a multiple of 5760 so the value is never negative
  localparam int unsigned UW        = 21;
  localparam logic [UW-1:0] HueBias = 21'd529920;  // 92 * 5760
  localparam int unsigned HueFull   = 5760;
  // floor(y / 45) = (y * 23302) >> 20 for y < 74898
  localparam logic [14:0] Recip45   = 15'd23302;

  localparam int unsigned HW        = 13;  // wrapped hue, 0..5759
  localparam int unsigned KW        = 11;  // secondary weight, 0..960
  localparam logic [HW-1:0] Sector  = 13'd960;

  localparam int unsigned CW = 25;  // chroma / offset, Q1.24 up to 1.0
  localparam int unsigned TW = 34;  // terms in units of 2^-24/960

  // Channel = round(T * 10000 / (960 * 2^24)) = floor((T*625 + 15*2^25) / 2^26) / 15
  localparam logic [9:0]  Scale625  = 10'd625;
  localparam logic [44:0] RoundBias = 45'd503316480;  // 15 * 2^25
  localparam int unsigned YW        = 18;
  // floor(y / 15) = (y * 1118482) >> 24 for y < 1.19e6
  localparam logic [20:0] Recip15   = 21'd1118482;

  typedef struct packed {
    logic [UW-1:0]    hue_u;
    logic [7:0]       wraps;
    logic [CW-1:0]    chroma;
    logic [UnitW-1:0] val;
    logic             invalid;
  } st1_t;

  typedef struct packed {
    logic [2:0]    sector;
    logic [KW-1:0] weight;
    logic [CW-1:0] chroma;
    logic [CW-1:0] offset;
    logic          invalid;
  } st2_t;

  typedef struct packed {
    logic [2:0]    sector;
    logic [TW-1:0] cs;
    logic [TW-1:0] xs;
    logic [TW-1:0] ms;
    logic          invalid;
  } st3_t;

  typedef struct packed {
    logic [YW-1:0] y_r;
    logic [YW-1:0] y_g;
    logic [YW-1:0] y_b;
    logic          invalid;
  } st4_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic           invalid;
  } st5_t;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: five-stage fixed-point pipeline with stream handshakes.
// Depends on rtl/hsv2rgb_pkg.sv for constants and stage payload types.
`timescale 1ns / 1ps
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   hue[19:0] saturation[33:20] brightness[47:34]  -
//  m_axis    out  red[13:0] green[27:14] blue[41:28] zero[47:42] invalid
//
//  One color per clock sustained while the output is ready; an accepted beat
//  passes through the five stages wrap -> sector -> products -> scaling ->
//  divide-by-15 into the output register and can leave from there.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage advances when it is empty or the stage after it moves, so
//  bubbles collapse and a stalled output holds its beat without loss.

module hsv_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // hue[19:0], saturation[33:20], brightness[47:34]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // red[13:0], green[27:14], blue[41:28], zero fill[47:42]
  output logic [47:0] m_axis_tdata_o,
  // invalid[0]
  output logic        m_axis_tuser_o
);

  localparam int unsigned NS = hsv2rgb_pkg::NumStages;

  logic [NS-1:0] vld_q, vld_d;
  logic [NS-1:0] adv;  // stage i loads this cycle

  // Backpressure: a stage takes new data when empty or when its contents move on.
  always_comb begin
    adv[NS-1] = ~vld_q[NS-1] | m_axis_tready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = ~vld_q[i] | adv[i+1];
    end
  end

  assign s_axis_tready_o = adv[0];

  always_comb begin
    vld_d[0] = adv[0] ? s_axis_tvalid_i : vld_q[0];
    for (int i = 1; i < NS; i++) begin
      vld_d[i] = adv[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: range check, bias hue positive, count whole turns, chroma v*s
  // ---------------------------------------------------------------------
  logic signed [hsv2rgb_pkg::HueW-1:0] hue_in;
  logic signed [hsv2rgb_pkg::QW-1:0]   sat_in, bri_in;
  logic [hsv2rgb_pkg::UW-1:0]          hue_u;
  logic [28:0]                         wrap_prod;
  logic [25:0]                         chroma_prod;
  hsv2rgb_pkg::st1_t                   st1_d, st1_q;

  assign hue_in = s_axis_tdata_i[19:0];
  assign sat_in = s_axis_tdata_i[33:20];
  assign bri_in = s_axis_tdata_i[47:34];

  always_comb begin
    hue_u       = {hue_in[hsv2rgb_pkg::HueW-1], hue_in} + hsv2rgb_pkg::HueBias;
    // floor(hue_u / 5760) = floor((hue_u >> 7) / 45)
    wrap_prod   = hue_u[20:7] * hsv2rgb_pkg::Recip45;
    chroma_prod = bri_in[12:0] * sat_in[12:0];
    st1_d.hue_u   = hue_u;
    st1_d.wraps   = wrap_prod[27:20];
    st1_d.chroma  = chroma_prod[24:0];
    st1_d.val     = bri_in[12:0];
    st1_d.invalid = (sat_in < 0) || (sat_in > 14'sd4096) ||
                    (bri_in < 0) || (bri_in > 14'sd4096);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      st1_q <= st1_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: wrapped hue, sector and fraction, secondary weight, m = v - c
  // ---------------------------------------------------------------------
  logic [hsv2rgb_pkg::UW-1:0] turns;
  logic [hsv2rgb_pkg::HW-1:0] hue_w, frac;
  logic [2:0]                 sector;
  hsv2rgb_pkg::st2_t          st2_d, st2_q;

  always_comb begin
    // 5760 = 4096 + 1024 + 512 + 128
    turns = ({13'd0, st1_q.wraps} << 12) + ({13'd0, st1_q.wraps} << 10) +
            ({13'd0, st1_q.wraps} << 9) + ({13'd0, st1_q.wraps} << 7);
    hue_w = hsv2rgb_pkg::HW'(st1_q.hue_u - turns);

    if (hue_w >= 5 * hsv2rgb_pkg::Sector) begin
      sector = 3'd5;
      frac   = hue_w - 13'(5 * hsv2rgb_pkg::Sector);
    end else if (hue_w >= 4 * hsv2rgb_pkg::Sector) begin
      sector = 3'd4;
      frac   = hue_w - 13'(4 * hsv2rgb_pkg::Sector);
    end else if (hue_w >= 3 * hsv2rgb_pkg::Sector) begin
      sector = 3'd3;
      frac   = hue_w - 13'(3 * hsv2rgb_pkg::Sector);
    end else if (hue_w >= 2 * hsv2rgb_pkg::Sector) begin
      sector = 3'd2;
      frac   = hue_w - 13'(2 * hsv2rgb_pkg::Sector);
    end else if (hue_w >= hsv2rgb_pkg::Sector) begin
      sector = 3'd1;
      frac   = hue_w - hsv2rgb_pkg::Sector;
    end else begin
      sector = 3'd0;
      frac   = hue_w;
    end

    st2_d.sector  = sector;
    st2_d.weight  = sector[0] ? hsv2rgb_pkg::KW'(hsv2rgb_pkg::Sector - frac)
                              : hsv2rgb_pkg::KW'(frac);
    st2_d.chroma  = st1_q.chroma;
    st2_d.offset  = {st1_q.val, 12'd0} - st1_q.chroma;
    st2_d.invalid = st1_q.invalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      st2_q <= st2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: terms in units of 2^-24/960: c*960, c*k, m*960
  // ---------------------------------------------------------------------
  logic [35:0]       xs_prod;
  hsv2rgb_pkg::st3_t st3_d, st3_q;

  always_comb begin
    xs_prod = st2_q.chroma * st2_q.weight;
    // 960 = 1024 - 64
    st3_d.cs      = ({9'd0, st2_q.chroma} << 10) - ({9'd0, st2_q.chroma} << 6);
    st3_d.ms      = ({9'd0, st2_q.offset} << 10) - ({9'd0, st2_q.offset} << 6);
    st3_d.xs      = xs_prod[hsv2rgb_pkg::TW-1:0];
    st3_d.sector  = st2_q.sector;
    st3_d.invalid = st2_q.invalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      st3_q <= st3_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: pick primaries per sector, add offset, scale by 625 and round
  // ---------------------------------------------------------------------
  logic [hsv2rgb_pkg::TW-1:0] pr, pg, pb, tr, tg, tb;
  logic [44:0]                sr, sg, sb;
  hsv2rgb_pkg::st4_t          st4_d, st4_q;

  always_comb begin
    case (st3_q.sector)
      3'd0: begin pr = st3_q.cs; pg = st3_q.xs; pb = '0;       end
      3'd1: begin pr = st3_q.xs; pg = st3_q.cs; pb = '0;       end
      3'd2: begin pr = '0;       pg = st3_q.cs; pb = st3_q.xs; end
      3'd3: begin pr = '0;       pg = st3_q.xs; pb = st3_q.cs; end
      3'd4: begin pr = st3_q.xs; pg = '0;       pb = st3_q.cs; end
      default: begin pr = st3_q.cs; pg = '0;    pb = st3_q.xs; end
    endcase
    tr = pr + st3_q.ms;
    tg = pg + st3_q.ms;
    tb = pb + st3_q.ms;
    sr = tr * hsv2rgb_pkg::Scale625 + hsv2rgb_pkg::RoundBias;
    sg = tg * hsv2rgb_pkg::Scale625 + hsv2rgb_pkg::RoundBias;
    sb = tb * hsv2rgb_pkg::Scale625 + hsv2rgb_pkg::RoundBias;
    st4_d.y_r     = sr[43:26];
    st4_d.y_g     = sg[43:26];
    st4_d.y_b     = sb[43:26];
    st4_d.invalid = st3_q.invalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      st4_q <= st4_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: divide by 15 through the reciprocal, zero invalid beats
  // ---------------------------------------------------------------------
  logic [38:0]       qr, qg, qb;
  hsv2rgb_pkg::st5_t st5_d, st5_q;

  always_comb begin
    qr = st4_q.y_r * hsv2rgb_pkg::Recip15;
    qg = st4_q.y_g * hsv2rgb_pkg::Recip15;
    qb = st4_q.y_b * hsv2rgb_pkg::Recip15;
    st5_d.red     = st4_q.invalid ? '0 : qr[37:24];
    st5_d.green   = st4_q.invalid ? '0 : qg[37:24];
    st5_d.blue    = st4_q.invalid ? '0 : qb[37:24];
    st5_d.invalid = st4_q.invalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      st5_q <= st5_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NS-1];
  assign m_axis_tdata_o  = {6'd0, st5_q.blue, st5_q.green, st5_q.red};
  assign m_axis_tuser_o  = st5_q.invalid;

`ifndef SYNTHESIS
  // An accepted beat lands in the first stage.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted beat not captured in stage 1");

  // A full pipe with a stalled output takes nothing new.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while pipeline full and stalled");

  // Invalid beats carry zero color.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o == '0))
    else $error("invalid beat with nonzero color");

  // Channels never exceed full scale.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (st5_q.red <= 14'd10000) && (st5_q.green <= 14'd10000) &&
                        (st5_q.blue <= 14'd10000))
    else $error("channel above 10000");
`endif

endmodule
